// ===== rtl/mseg_pkg.sv =====
// Shared types, codes and constants for the multi-stage envelope generator.
// No dependencies; imported by mseg_div and the top level.
`timescale 1ns / 1ps
`default_nettype none
package mseg_pkg;

   // Stage table depth and the idle stage index
   localparam int unsigned MAX_STAGES = 16;
   localparam logic [4:0] STAGE_IDLE  = 5'd16;

   // Fixed-point constants
   localparam logic signed [31:0] EPS_Q30 = 32'sd1073742;     // 0.001 in Q2.30
   localparam logic signed [31:0] ONE_Q27 = 32'sd134217728;   // 1.0 in Q5.27
   localparam logic [31:0]        LN2_Q32 = 32'd2977044472;   // ln 2 in Q0.32

   // Reset values of the configuration registers
   localparam logic [4:0]  RST_STAGE_COUNT = 5'd1;
   localparam logic [4:0]  RST_SUSTAIN     = 5'd16;
   localparam logic [17:0] RST_RATE        = 18'd44100;

   // Iteration counts of the shared units
   localparam logic [4:0] LOG_ROUNDS = 5'd24;
   localparam logic [5:0] DIV_STEPS  = 6'd34;

   // Transaction function codes
   typedef enum logic [1:0] {
      FUNC_TICK    = 2'd0,
      FUNC_START   = 2'd1,
      FUNC_RELEASE = 2'd2,
      FUNC_WRITE   = 2'd3
   } func_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_STAGE_COUNT = 2'd0,
      CSR_SUSTAIN     = 2'd1,
      CSR_START_VALUE = 2'd2,
      CSR_SAMPLE_RATE = 2'd3
   } csr_type;

   // Divider request and response
   typedef struct packed {
      logic        start;
      logic [33:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [33:0] quotient;
   } div_rsp_type;

   // Clamp a wide signed value to the signed 32-bit range
   function automatic logic [31:0] sat32(input logic signed [37:0] v);
      logic [31:0] r;
      if (v > 38'sh007FFFFFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < 38'sh3F80000000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/multi_stage_envelope_generator_core.sv =====
// Top level of the multi-stage envelope generator: stage table, sequencer,
// shared 32x32 multiplier. Depends on mseg_pkg and mseg_div.
//
//   channel | direction | handshake         | payload
//   req_    | in        | req_valid/ready   | func, entry_index/peak/time/curve
//   rsp_    | out       | rsp_valid/ready   | level_out, playing, stage_out
//   csr_    | in        | csr_we            | csr_addr, csr_wdata
//
// One transaction at a time; req_ready is high only while the sequencer idles.
// A linear stage start runs the length product, then the 34-step divider. An exponential
// stage start runs two logarithms of 24 squaring rounds plus up to 30 normalising shifts
// each, then the divider. A zero length skips the logarithms and the divider. A tick
// that opens a stage then also takes the step.
// Synchronous active-high reset; no clearing pass. A stalled rsp_ holds the result.
`timescale 1ns / 1ps
`default_nettype none
module multi_stage_envelope_generator_core
   import mseg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [3:0]  req_entry_index,
   input  wire logic [31:0] req_entry_peak,
   input  wire logic [31:0] req_entry_time,
   input  wire logic        req_entry_curve,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_level_out,
   output logic             rsp_playing,
   output logic [4:0]       rsp_stage_out,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [31:0] csr_wdata
);

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_LEN_MUL  = 12'b0000_0000_0010,
      ST_LEN_SET  = 12'b0000_0000_0100,
      ST_NORM     = 12'b0000_0000_1000,
      ST_SQ_MUL   = 12'b0000_0001_0000,
      ST_SQ_SET   = 12'b0000_0010_0000,
      ST_D_MUL    = 12'b0000_0100_0000,
      ST_D_SET    = 12'b0000_1000_0000,
      ST_DIV      = 12'b0001_0000_0000,
      ST_STEP     = 12'b0010_0000_0000,
      ST_STEP_SET = 12'b0100_0000_0000,
      ST_OUT      = 12'b1000_0000_0000
   } state_type;

   // Configuration
   logic [4:0]         stage_count_ff;
   logic [4:0]         sustain_ff;
   logic signed [31:0] start_value_ff;
   logic [17:0]        rate_ff;

   // Stage table
   logic [31:0] peak_mem  [MAX_STAGES];
   logic [31:0] time_mem  [MAX_STAGES];
   logic        curve_mem [MAX_STAGES];

   // Envelope and sequencer state
   state_type          state_ff, state_in;
   logic signed [31:0] level_ff, level_in;
   logic signed [31:0] sf_ff, sf_in;
   logic [4:0]         cs_ff, cs_in;
   logic [31:0]        smp_cnt_ff, smp_cnt_in;
   logic [31:0]        len_ff, len_in;
   logic               sp_ff, sp_in;
   logic signed [31:0] from_ff, from_in;
   logic               step_after_ff, step_after_in;
   logic [31:0]        m_ff, m_in;
   logic [4:0]         k_ff, k_in;
   logic [23:0]        r_ff, r_in;
   logic [4:0]         rnd_ff, rnd_in;
   logic               pass_ff, pass_in;
   logic signed [31:0] lg_e_ff, lg_e_in;
   logic               neg_ff, neg_in;
   logic [31:0]        dmag_ff, dmag_in;
   logic               exp_mode_ff, exp_mode_in;
   logic               stepped_ff, stepped_in;
   logic signed [31:0] sample_ff, sample_in;
   logic [63:0]        prod_ff, prod_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_level_ff, rsp_level_in;
   logic               rsp_playing_ff, rsp_playing_in;
   logic [4:0]         rsp_stage_ff, rsp_stage_in;

   // Shared multiplier operands and divider link
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // Helpers
   logic               req_fire;
   logic [4:0]         eff_cnt;
   logic signed [31:0] peak_rd;
   logic [31:0]        time_rd;
   logic               curve_rd;
   logic               held;
   logic [4:0]         cs_next;
   logic               end_hold;
   logic [33:0]        len34;
   logic [31:0]        len_cur;
   logic [32:0]        lin_diff;
   logic [32:0]        lin_mag;
   logic signed [31:0] exp_s;
   logic signed [31:0] exp_e;
   logic [31:0]        sq_t;
   logic [23:0]        r_new;
   logic [31:0]        lg_val;
   logic [31:0]        d_val;
   logic [37:0]        q_ext;
   logic [37:0]        q_signed;
   logic [37:0]        sf_wide;
   logic [37:0]        add_wide;
   logic [31:0]        lvl_mag;
   logic [31:0]        sf_mag;
   logic [37:0]        stp_ext;
   state_type          fin_state;

   assign req_fire = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Stages in use, clamped to the table
   assign eff_cnt = (stage_count_ff == 5'd0) ? 5'd1 :
                    (stage_count_ff > STAGE_IDLE) ? STAGE_IDLE : stage_count_ff;

   // Single read port on the stage table at the current stage
   assign peak_rd  = peak_mem[cs_ff[3:0]];
   assign time_rd  = time_mem[cs_ff[3:0]];
   assign curve_rd = curve_mem[cs_ff[3:0]];

   assign held     = (cs_ff >= eff_cnt) || ((cs_ff == sustain_ff) && !sp_ff);
   assign cs_next  = cs_ff + 5'd1;
   assign end_hold = (cs_next >= eff_cnt) || (!sp_ff && (cs_next == sustain_ff));

   // Stage length from the registered product
   assign len34   = prod_ff[49:16];
   assign len_cur = (|len34[33:32]) ? 32'hFFFF_FFFF : len34[31:0];

   // Linear slope numerator
   assign lin_diff = {peak_rd[31], peak_rd} - {from_ff[31], from_ff};
   assign lin_mag  = lin_diff[32] ? (33'd0 - lin_diff) : lin_diff;

   // Exponential end points, non-positive taken as 0.001
   assign exp_s = (from_ff > 32'sd0) ? from_ff : EPS_Q30;
   assign exp_e = (peak_rd > 32'sd0) ? peak_rd : EPS_Q30;

   // One squaring round of the logarithm
   assign sq_t   = prod_ff[61:30];
   assign r_new  = {r_ff[22:0], sq_t[31]};
   assign lg_val = {8'd0, r_new} - {3'd0, k_ff, 24'd0};
   assign d_val  = lg_e_ff - lg_val;

   // Signed quotient and the resulting step factor
   assign q_ext    = {4'd0, div_rsp.quotient};
   assign q_signed = neg_ff ? (38'd0 - q_ext) : q_ext;
   assign sf_wide  = exp_mode_ff ? (q_signed + {{6{1'b0}}, ONE_Q27}) : q_signed;

   // Step arithmetic
   assign add_wide = {{6{level_ff[31]}}, level_ff} + {{6{sf_ff[31]}}, sf_ff};
   assign lvl_mag  = level_ff[31] ? (32'd0 - level_ff) : level_ff;
   assign sf_mag   = sf_ff[31] ? (32'd0 - sf_ff) : sf_ff;
   assign stp_ext  = neg_ff ? (38'd0 - {1'b0, prod_ff[63:27]}) : {1'b0, prod_ff[63:27]};

   assign fin_state = step_after_ff ? ST_STEP : ST_OUT;

   // Shared 32x32 multiplier, product registered
   assign prod_in = mul_a * mul_b;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      sf_in         = sf_ff;
      cs_in         = cs_ff;
      smp_cnt_in    = smp_cnt_ff;
      len_in        = len_ff;
      sp_in         = sp_ff;
      from_in       = from_ff;
      step_after_in = step_after_ff;
      m_in          = m_ff;
      k_in          = k_ff;
      r_in          = r_ff;
      rnd_in        = rnd_ff;
      pass_in       = pass_ff;
      lg_e_in       = lg_e_ff;
      neg_in        = neg_ff;
      dmag_in       = dmag_ff;
      exp_mode_in   = exp_mode_ff;
      stepped_in    = stepped_ff;
      sample_in     = sample_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_level_in  = rsp_level_ff;
      rsp_playing_in = rsp_playing_ff;
      rsp_stage_in  = rsp_stage_ff;
      mul_a         = '0;
      mul_b         = '0;
      div_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               stepped_in    = 1'b0;
               step_after_in = 1'b0;
               unique case (func_type'(req_func))
                  FUNC_WRITE: begin
                     state_in = ST_OUT;
                  end
                  FUNC_START: begin
                     cs_in    = 5'd0;
                     from_in  = start_value_ff;
                     sp_in    = 1'b0;
                     state_in = ST_LEN_MUL;
                  end
                  FUNC_RELEASE: begin
                     if (cs_ff < eff_cnt) begin
                        sp_in = 1'b1;
                        if (cs_ff != sustain_ff) begin
                           cs_in = eff_cnt - 5'd1;
                        end
                        from_in  = level_ff;
                        state_in = ST_LEN_MUL;
                     end else begin
                        state_in = ST_OUT;
                     end
                  end
                  FUNC_TICK: begin
                     if (held) begin
                        state_in = ST_OUT;
                     end else if (smp_cnt_ff == len_ff) begin
                        cs_in = cs_next;
                        if (end_hold) begin
                           level_in = peak_rd;
                           sf_in    = '0;
                           state_in = ST_OUT;
                        end else begin
                           from_in       = peak_rd;
                           step_after_in = 1'b1;
                           state_in      = ST_LEN_MUL;
                        end
                     end else begin
                        state_in = ST_STEP;
                     end
                  end
                  default: state_in = ST_OUT;
               endcase
            end
         end

         // Stage length = time * rate >> 16
         ST_LEN_MUL: begin
            mul_a    = time_rd;
            mul_b    = {14'd0, rate_ff};
            state_in = ST_LEN_SET;
         end

         ST_LEN_SET: begin
            len_in     = len_cur;
            smp_cnt_in = '0;
            if (!curve_rd) begin
               level_in    = from_ff;
               exp_mode_in = 1'b0;
               if (len_cur == 32'd0) begin
                  sf_in    = '0;
                  state_in = fin_state;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {1'b0, lin_mag};
                  div_req.divisor  = len_cur;
                  neg_in           = lin_diff[32];
                  state_in         = ST_DIV;
               end
            end else begin
               level_in    = exp_s;
               from_in     = exp_s;
               exp_mode_in = 1'b1;
               if (len_cur == 32'd0) begin
                  sf_in    = ONE_Q27;
                  state_in = fin_state;
               end else begin
                  m_in     = exp_e;
                  k_in     = '0;
                  r_in     = '0;
                  rnd_in   = '0;
                  pass_in  = 1'b0;
                  state_in = ST_NORM;
               end
            end
         end

         // Normalise the mantissa one bit a cycle
         ST_NORM: begin
            if (m_ff[30]) begin
               state_in = ST_SQ_MUL;
            end else begin
               m_in = {m_ff[30:0], 1'b0};
               k_in = k_ff + 5'd1;
            end
         end

         ST_SQ_MUL: begin
            mul_a    = m_ff;
            mul_b    = m_ff;
            state_in = ST_SQ_SET;
         end

         // Square, take one result bit, renormalise
         ST_SQ_SET: begin
            m_in   = sq_t[31] ? {1'b0, sq_t[31:1]} : sq_t;
            r_in   = r_new;
            rnd_in = rnd_ff + 5'd1;
            if (rnd_ff == (LOG_ROUNDS - 5'd1)) begin
               if (!pass_ff) begin
                  lg_e_in  = lg_val;
                  m_in     = from_ff;
                  k_in     = '0;
                  r_in     = '0;
                  rnd_in   = '0;
                  pass_in  = 1'b1;
                  state_in = ST_NORM;
               end else begin
                  dmag_in  = d_val[31] ? (32'd0 - d_val) : d_val;
                  neg_in   = d_val[31];
                  state_in = ST_D_MUL;
               end
            end else begin
               state_in = ST_SQ_MUL;
            end
         end

         ST_D_MUL: begin
            mul_a    = dmag_ff;
            mul_b    = LN2_Q32;
            state_in = ST_D_SET;
         end

         ST_D_SET: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod_ff[62:29];
            div_req.divisor  = len_ff;
            state_in         = ST_DIV;
         end

         ST_DIV: begin
            if (div_rsp.done) begin
               sf_in    = sat32(sf_wide);
               state_in = fin_state;
            end
         end

         // Emit the current level, then advance it
         ST_STEP: begin
            sample_in  = level_ff;
            stepped_in = 1'b1;
            smp_cnt_in = smp_cnt_ff + 32'd1;
            if (!curve_rd) begin
               level_in = sat32(add_wide);
               state_in = ST_OUT;
            end else begin
               mul_a    = lvl_mag;
               mul_b    = sf_mag;
               neg_in   = level_ff[31] ^ sf_ff[31];
               state_in = ST_STEP_SET;
            end
         end

         ST_STEP_SET: begin
            level_in = sat32(stp_ext);
            state_in = ST_OUT;
         end

         // Load the result register once it is free
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_level_in   = stepped_ff ? sample_ff : level_ff;
               rsp_playing_in = cs_ff < eff_cnt;
               rsp_stage_in   = cs_ff;
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         level_ff       <= '0;
         sf_ff          <= '0;
         cs_ff          <= STAGE_IDLE;
         smp_cnt_ff     <= '0;
         len_ff         <= '0;
         sp_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         stage_count_ff <= RST_STAGE_COUNT;
         sustain_ff     <= RST_SUSTAIN;
         start_value_ff <= '0;
         rate_ff        <= RST_RATE;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         sf_ff        <= sf_in;
         cs_ff        <= cs_in;
         smp_cnt_ff   <= smp_cnt_in;
         len_ff       <= len_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_type'(csr_addr))
               CSR_STAGE_COUNT: stage_count_ff <= csr_wdata[4:0];
               CSR_SUSTAIN:     sustain_ff     <= csr_wdata[4:0];
               CSR_START_VALUE: start_value_ff <= csr_wdata;
               CSR_SAMPLE_RATE: rate_ff        <= csr_wdata[17:0];
               default:         rate_ff        <= rate_ff;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      from_ff        <= from_in;
      step_after_ff  <= step_after_in;
      m_ff           <= m_in;
      k_ff           <= k_in;
      r_ff           <= r_in;
      rnd_ff         <= rnd_in;
      pass_ff        <= pass_in;
      lg_e_ff        <= lg_e_in;
      neg_ff         <= neg_in;
      dmag_ff        <= dmag_in;
      exp_mode_ff    <= exp_mode_in;
      stepped_ff     <= stepped_in;
      sample_ff      <= sample_in;
      prod_ff        <= prod_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_playing_ff <= rsp_playing_in;
      rsp_stage_ff   <= rsp_stage_in;
   end

   // Stage table write
   always_ff @(posedge clock) begin
      if (req_fire && (func_type'(req_func) == FUNC_WRITE)) begin
         peak_mem[req_entry_index]  <= req_entry_peak;
         time_mem[req_entry_index]  <= req_entry_time;
         curve_mem[req_entry_index] <= req_entry_curve;
      end
   end

   mseg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_level_out = rsp_level_ff;
   assign rsp_playing   = rsp_playing_ff;
   assign rsp_stage_out = rsp_stage_ff;

`ifndef SYNTHESIS
   // An accepted transaction takes req_ready low in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready held high after an accepted transaction");

   // The divider only finishes while the sequencer waits on it
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside its wait state");

   // The stage index never passes the idle code
   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      cs_ff <= STAGE_IDLE)
      else $error("stage index beyond idle code");
`endif

endmodule
`default_nettype wire

// ===== rtl/mseg_div.sv =====
// Iterative restoring divider: 34-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on mseg_pkg for the request and response structs.
`timescale 1ns / 1ps
`default_nettype none
module mseg_div
   import mseg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [33:0] dvd_ff;
   logic [31:0] rem_ff;
   logic [31:0] dsr_ff;

   logic [32:0] trial;
   logic [32:0] diff;
   logic        ge;

   // Trial subtract of the next partial remainder
   assign trial = {rem_ff, dvd_ff[33]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign ge    = trial >= {1'b0, dsr_ff};

   // Sequence the iterations
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_STEPS;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Shift quotient bits into the dividend register
   always_ff @(posedge clock) begin
      if (req.start) begin
         dvd_ff <= req.dividend;
         rem_ff <= '0;
         dsr_ff <= req.divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[31:0] : trial[31:0];
         dvd_ff <= {dvd_ff[32:0], ge};
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = dvd_ff;

endmodule
`default_nettype wire

// ===== test/multi_stage_envelope_generator_core_tb.sv =====
// Self-checking testbench for multi_stage_envelope_generator_core: directed and randomised
// stage tables and envelope sequences checked against a bit-exact predictor.
// Depends on mseg_pkg and the core RTL (with mseg_div).
`timescale 1ns / 1ps
module multi_stage_envelope_generator_core_tb;
   import mseg_pkg::*;

   typedef struct {
      func_type    func;
      logic [3:0]  idx;
      logic [31:0] peak;
      logic [31:0] dur;
      logic        curve;
   } env_txn_type;

   typedef struct {
      logic [31:0] level;
      logic        playing;
      logic [4:0]  stage;
   } env_sample_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire         req_ready;
   logic [1:0]  req_func = '0;
   logic [3:0]  req_entry_index = '0;
   logic [31:0] req_entry_peak = '0;
   logic [31:0] req_entry_time = '0;
   logic        req_entry_curve = 1'b0;
   wire         rsp_valid;
   logic        rsp_ready = 1'b0;
   wire  [31:0] rsp_level_out;
   wire         rsp_playing;
   wire  [4:0]  rsp_stage_out;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [31:0] csr_wdata = '0;

   multi_stage_envelope_generator_core dut (.*);

   always #4 clock = ~clock;

   // Predictor state
   longint     peak_tab [16];
   longint     time_tab [16];
   bit         curve_tab [16];
   longint     env_level = 0;
   longint     env_step = 0;
   int         env_stage = 16;
   longint     env_count = 0;
   longint     env_len = 0;
   bit         env_released = 0;
   int         cfg_count = 1;
   int         cfg_sustain = 16;
   longint     cfg_start = 0;
   longint     cfg_rate = 44100;

   env_txn_type    pending_txns [$];
   env_sample_type expected_samples [$];
   int         errors = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   logic       long_hold_req = 1'b0;
   int         hold_left = 0;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic int active_stages();
      if (cfg_count == 0) return 1;
      if (cfg_count > 16) return 16;
      return cfg_count;
   endfunction

   // log2 of a positive Q.30 value, 24 fraction bits
   function automatic longint log2_q24(longint unsigned x);
      int p;
      longint unsigned m;
      longint r;
      p = 63;
      r = 0;
      while (p > 0 && !x[p]) p--;
      m = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
      for (int i = 0; i < 24; i++) begin
         m = (m * m) >> 30;
         r = r << 1;
         if (m >= 64'd2147483648) begin
            m = m >> 1;
            r = r | 1;
         end
      end
      return longint'(p - 30) * 64'sd16777216 + r;
   endfunction

   function automatic longint scale_q27(longint l, longint f);
      bit neg;
      longint unsigned ul, uf, hi, lo, r;
      neg = (l < 0) != (f < 0);
      ul = (l < 0) ? -l : l;
      uf = (f < 0) ? -f : f;
      hi = ul * (uf >> 16);
      lo = ul * (uf & 64'hFFFF);
      r = (hi >> 11) + ((((hi & 64'h7FF) << 16) + lo) >> 27);
      return clamp32(neg ? -longint'(r) : longint'(r));
   endfunction

   function automatic void enter_stage(longint from, longint to, longint dur, bit curve);
      longint unsigned len;
      longint s, e, d;
      len = (longint'(dur) * cfg_rate) >> 16;
      if (len > 64'hFFFFFFFF) len = 64'hFFFFFFFF;
      env_len = len;
      env_count = 0;
      if (curve) begin
         s = (from > 0) ? from : longint'(EPS_Q30);
         e = (to > 0) ? to : longint'(EPS_Q30);
         env_level = s;
         if (len == 0) begin
            env_step = longint'(ONE_Q27);
         end else begin
            d = log2_q24(e) - log2_q24(s);
            env_step = clamp32(longint'(ONE_Q27) + (d * longint'(LN2_Q32)) / longint'(len << 29));
         end
      end else begin
         env_level = from;
         env_step = (len == 0) ? 0 : clamp32((to - from) / longint'(len));
      end
   endfunction

   // Advance the envelope by one transaction and return its sample
   function automatic env_sample_type advance_envelope(env_txn_type t);
      env_sample_type o;
      longint smp;
      bit held;
      int cnt;
      cnt = active_stages();
      smp = env_level;
      case (t.func)
         FUNC_WRITE: begin
            peak_tab[t.idx] = longint'(signed'(t.peak));
            time_tab[t.idx] = t.dur;
            curve_tab[t.idx] = t.curve;
         end
         FUNC_START: begin
            env_stage = 0;
            enter_stage(cfg_start, peak_tab[0], time_tab[0], curve_tab[0]);
            env_released = 0;
            smp = env_level;
         end
         FUNC_RELEASE: begin
            if (env_stage < cnt) begin
               env_released = 1;
               if (env_stage != cfg_sustain) env_stage = cnt - 1;
               enter_stage(env_level, peak_tab[env_stage], time_tab[env_stage],
                           curve_tab[env_stage]);
            end
            smp = env_level;
         end
         default: begin
            if (!(env_stage >= cnt || (env_stage == cfg_sustain && !env_released))) begin
               held = 0;
               if (env_count == env_len) begin
                  env_stage++;
                  if (env_stage >= cnt || (!env_released && env_stage == cfg_sustain)) begin
                     env_level = clamp32(peak_tab[env_stage - 1]);
                     env_step = 0;
                     held = 1;
                  end else begin
                     enter_stage(peak_tab[env_stage - 1], peak_tab[env_stage],
                                 time_tab[env_stage], curve_tab[env_stage]);
                  end
               end
               smp = env_level;
               if (!held) begin
                  if (curve_tab[env_stage]) env_level = scale_q27(env_level, env_step);
                  else env_level = clamp32(env_level + env_step);
                  env_count = (env_count + 1) & 64'hFFFFFFFF;
               end
            end
         end
      endcase
      o.level = clamp32(smp);
      o.playing = env_stage < cnt;
      o.stage = env_stage[4:0];
      return o;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: %s got %0h expected %0h", $time, what, got, want);
      errors++;
   endtask

   // Driver: predict on acceptance, then offer the next pending transaction
   always @(posedge clock) begin
      env_txn_type t;
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            t.func = func_type'(req_func);
            t.idx = req_entry_index;
            t.peak = req_entry_peak;
            t.dur = req_entry_time;
            t.curve = req_entry_curve;
            expected_samples.push_back(advance_envelope(t));
            next_valid = 1'b0;
         end
         if (!next_valid && pending_txns.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            t = pending_txns.pop_front();
            req_func <= t.func;
            req_entry_index <= t.idx;
            req_entry_peak <= t.peak;
            req_entry_time <= t.dur;
            req_entry_curve <= t.curve;
            next_valid = 1'b1;
         end
         req_valid <= next_valid;
      end
   end

   // Long receiver hold: count the stalled cycles down
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (long_hold_req) begin
         hold_left <= 600;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: compare each response with the oldest prediction
   always @(posedge clock) begin
      env_sample_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_level_out, 0);
            end else begin
               e = expected_samples.pop_front();
               if (rsp_level_out !== e.level) report_mismatch("level_out", rsp_level_out, e.level);
               if (rsp_playing !== e.playing) report_mismatch("playing", rsp_playing, e.playing);
               if (rsp_stage_out !== e.stage) report_mismatch("stage_out", rsp_stage_out, e.stage);
            end
         end
         if (long_hold_req || hold_left > 1) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= $urandom_range(99) >= recv_idle_pct;
         end
      end
   end

   // Duration giving a short stage at the current rate
   function automatic logic [31:0] short_time(int samples);
      return 32'(((longint'(samples) << 16) + cfg_rate - 1) / cfg_rate);
   endfunction

   task automatic push_txn(func_type f, int idx, logic [31:0] pk, logic [31:0] dur, bit c);
      env_txn_type t;
      t.func = f;
      t.idx = idx[3:0];
      t.peak = pk;
      t.dur = dur;
      t.curve = c;
      pending_txns.push_back(t);
   endtask

   task automatic push_random_entry();
      logic [31:0] dur;
      case ($urandom_range(19))
         0: dur = $urandom;
         1: dur = 0;
         default: dur = short_time($urandom_range(12));
      endcase
      push_txn(FUNC_WRITE, $urandom_range(15), $urandom, dur, $urandom_range(1));
   endtask

   // Well-formed envelope runs with random content, plus some noise
   task automatic fill_phase(int n);
      int target;
      target = pending_txns.size() + n;
      while (pending_txns.size() < target) begin
         if ($urandom_range(9) == 0) begin
            if ($urandom_range(3) == 0) push_random_entry();
            else push_txn(func_type'($urandom_range(2)), $urandom_range(15), $urandom,
                          $urandom, $urandom_range(1));
         end else begin
            repeat ($urandom_range(3)) push_random_entry();
            push_txn(FUNC_START, $urandom_range(15), $urandom, $urandom, $urandom_range(1));
            repeat ($urandom_range(40, 5)) push_txn(FUNC_TICK, 0, 0, 0, 0);
            push_txn(FUNC_RELEASE, $urandom_range(15), $urandom, $urandom, $urandom_range(1));
            repeat ($urandom_range(25, 3)) push_txn(FUNC_TICK, 0, 0, 0, 0);
         end
      end
   endtask

   task automatic drain();
      while (pending_txns.size() > 0 || req_valid || expected_samples.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(csr_type a, logic [31:0] d);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= a;
      csr_wdata <= d;
      case (a)
         CSR_STAGE_COUNT: cfg_count = d[4:0];
         CSR_SUSTAIN:     cfg_sustain = d[4:0];
         CSR_START_VALUE: cfg_start = longint'(signed'(d));
         default:         cfg_rate = d[17:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(int cnt, int sus, logic [31:0] sv, int rate);
      write_csr(CSR_STAGE_COUNT, cnt);
      write_csr(CSR_SUSTAIN, sus);
      write_csr(CSR_START_VALUE, sv);
      write_csr(CSR_SAMPLE_RATE, rate);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle release and tick, full table with extreme entries
      push_txn(FUNC_RELEASE, 0, 0, 0, 0);
      push_txn(FUNC_TICK, 0, 0, 0, 0);
      for (int i = 0; i < 16; i++)
         push_txn(FUNC_WRITE, i, (i % 3 == 0) ? 32'h7FFF_FFFF : (i % 3 == 1) ? 32'h8000_0000 :
                  32'h0, (i == 0) ? 32'hFFFF_FFFF : short_time(i % 5), i % 2);
      push_txn(FUNC_START, 0, 0, 0, 0);
      push_txn(FUNC_TICK, 0, 0, 0, 0);
      push_txn(FUNC_RELEASE, 0, 0, 0, 0);
      push_txn(FUNC_WRITE, 0, 32'h4000_0000, 0, 0);
      push_txn(FUNC_START, 0, 0, 0, 0);
      repeat (3) push_txn(FUNC_TICK, 0, 0, 0, 0);
      drain();

      // Random phases under several settings and idling patterns
      configure(4, 2, 32'h0, 44100);
      fill_phase(450);
      repeat (50) @(posedge clock);
      long_hold_req <= 1'b1;
      @(posedge clock);
      long_hold_req <= 1'b0;
      drain();

      configure(16, 16, 32'h7FFF_FFFF, 1);
      send_idle_pct = 66;
      fill_phase(450);
      drain();

      configure(1, 0, 32'h8000_0000, 192000);
      send_idle_pct = 0;
      recv_idle_pct = 66;
      fill_phase(450);
      drain();

      configure(31, 31, $urandom, 3);
      send_idle_pct = 26;
      recv_idle_pct = 26;
      fill_phase(250);
      drain();

      configure(0, 1, $urandom, 22050);
      fill_phase(200);
      drain();

      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Hard stop
   initial begin
      #60_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
